// ===== sv/ncdf_pkg.sv =====
// Shared constants, fixed-point coefficients and sideband type for the normal CDF pipeline.
package ncdf_pkg;

    localparam int WF            = 40;
    localparam int IN_FRAC_BITS  = 16;
    localparam int OUT_FRAC_BITS = 32;
    localparam int K_BITS        = 10;
    localparam int DIV_QBITS     = 41;
    localparam int TAYLOR_TERMS  = 16;
    localparam int NUM_TERMS     = 7;
    localparam int DEN_TERMS     = 8;
    localparam int CF_TERMS      = 4;
    localparam int SHIFT_BIAS    = WF - OUT_FRAC_BITS;

    localparam logic [127:0] E2  = 128'd100;
    localparam logic [127:0] E12 = 128'd1000000000000;
    localparam logic [127:0] E13 = 128'd10000000000000;
    localparam logic [127:0] E14 = 128'd100000000000000;
    localparam logic [127:0] E15 = 128'd1000000000000000;
    localparam logic [127:0] E16 = 128'd10000000000000000;
    localparam logic [127:0] E18 = 128'd1000000000000000000;

    localparam logic [64:0] TWO64 = 65'h1_0000_0000_0000_0000;

    localparam logic [63:0] ONE_WF    = 64'h0000_0100_0000_0000;
    localparam logic [31:0] BIG_LIMIT = 32'(37) << IN_FRAC_BITS;

    localparam logic [63:0] LN2_C     = 64'((128'd693147180559945309 << WF) / E18);
    localparam logic [63:0] SPLIT_C   = 64'((128'd707106781186547 << WF) / E14);
    localparam logic [63:0] C065_C    = 64'((128'd65 << WF) / E2);
    localparam logic [63:0] SQRT2PI_C = 64'((128'd2506628274631 << WF) / E12);

    // reciprocals for the constant divides: floor(2^103 / ln2), floor(2^104 / sqrt(2*pi))
    localparam logic [63:0] RLN2_C     = 64'((128'd1 << 103) / {64'd0, LN2_C});
    localparam logic [63:0] RSQRT2PI_C = 64'((128'd1 << 104) / {64'd0, SQRT2PI_C});

    localparam logic [63:0] NUM_C [NUM_TERMS] = '{
        64'((128'd352624965998911 << WF) / E16),
        64'((128'd700383064443688 << WF) / E15),
        64'((128'd637396220353165 << WF) / E14),
        64'((128'd33912866078383  << WF) / E12),
        64'((128'd112079291497871 << WF) / E12),
        64'((128'd221213596169931 << WF) / E12),
        64'((128'd220206867912376 << WF) / E12)
    };

    localparam logic [63:0] DEN_C [DEN_TERMS] = '{
        64'((128'd883883476483184 << WF) / E16),
        64'((128'd175566716318264 << WF) / E14),
        64'((128'd16064177579207  << WF) / E12),
        64'((128'd867807322029461 << WF) / E13),
        64'((128'd296564248779674 << WF) / E12),
        64'((128'd637333633378831 << WF) / E12),
        64'((128'd793826512519948 << WF) / E12),
        64'((128'd440413735824752 << WF) / E12)
    };

    // floor(2^64 / n) for n = 1..16; n = 1 uses all ones, the correction step fixes it
    localparam logic [63:0] RECIP_C [TAYLOR_TERMS] = '{
        64'hFFFF_FFFF_FFFF_FFFF,
        64'(TWO64 / 65'd2),  64'(TWO64 / 65'd3),  64'(TWO64 / 65'd4),
        64'(TWO64 / 65'd5),  64'(TWO64 / 65'd6),  64'(TWO64 / 65'd7),
        64'(TWO64 / 65'd8),  64'(TWO64 / 65'd9),  64'(TWO64 / 65'd10),
        64'(TWO64 / 65'd11), 64'(TWO64 / 65'd12), 64'(TWO64 / 65'd13),
        64'(TWO64 / 65'd14), 64'(TWO64 / 65'd15), 64'(TWO64 / 65'd16)
    };

    typedef struct packed {
        logic              pos;
        logic              big;
        logic [63:0]       a;
        logic [K_BITS-1:0] k;
        logic [63:0]       m;
        logic [63:0]       w0;
        logic [63:0]       w1;
        logic [63:0]       t1;
    } t_side;

endpackage

// ===== sv/normal_cdf_rational.sv =====
// Throughput: one word per cycle when the output does not stall; the rate is set by
//   the fully pipelined chain of 51 two-stage multipliers and six 41-stage
//   restoring dividers.
// Backpressure: output stall freezes the whole chain; nothing is dropped or repeated.
// Reset: synchronous, active low; clears every valid bit, payload is left as is.
// Phi(x), unsigned Q0.32, saturated; Hart rational below 7.07, CF to 37, zero above.
module normal_cdf_rational (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_probability
);

    localparam int NT = ncdf_pkg::TAYLOR_TERMS;
    localparam int NN = ncdf_pkg::NUM_TERMS - 1;
    localparam int ND = ncdf_pkg::DEN_TERMS - 1;
    localparam int NC = ncdf_pkg::CF_TERMS;
    localparam int QB = ncdf_pkg::DIV_QBITS;
    localparam int KB = ncdf_pkg::K_BITS;

    // one global enable: the chain only moves when the output register can take a word
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // ---- input word and argument preparation ----
    logic            r_in_valid, r_pre_valid;
    logic [31:0]     r_in_x;
    ncdf_pkg::t_side r_pre_side, n_pre_side;

    always_comb begin
        logic        v_neg;
        logic [31:0] v_mag;
        v_neg      = r_in_x[31];
        v_mag      = v_neg ? 32'(-r_in_x) : r_in_x;    // most negative maps to 2^31
        n_pre_side = '0;
        n_pre_side.pos = !v_neg && (r_in_x != 32'd0);  // zero counts as not positive
        n_pre_side.big = (v_mag > ncdf_pkg::BIG_LIMIT);
        n_pre_side.a   = 64'(v_mag) << (ncdf_pkg::WF - ncdf_pkg::IN_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pre_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid  <= i_valid;
            r_pre_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_x     <= i_x_value;
            r_pre_side <= n_pre_side;
        end
    end

    // ---- y = a*a/2, then k = y / ln2 and r = remainder ----
    logic            w_sq_valid;
    logic [127:0]    w_sq_prod;
    ncdf_pkg::t_side w_sq_side, w_sq_g;

    ncdf_mul u_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_pre_valid),
        .i_a(r_pre_side.a), .i_b(r_pre_side.a), .i_side(r_pre_side),
        .o_valid(w_sq_valid), .o_prod(w_sq_prod), .o_side(w_sq_side)
    );

    // y rides in w0
    always_comb begin
        w_sq_g    = w_sq_side;
        w_sq_g.w0 = 64'(w_sq_prod[103:41]);
    end

    // k estimate by reciprocal: low by at most one
    logic            w_kq_valid;
    logic [127:0]    w_kq_prod;
    ncdf_pkg::t_side w_kq_side, w_kq_g;

    ncdf_mul u_kq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_sq_valid),
        .i_a(w_sq_g.w0), .i_b(ncdf_pkg::RLN2_C), .i_side(w_sq_g),
        .o_valid(w_kq_valid), .o_prod(w_kq_prod), .o_side(w_kq_side)
    );

    always_comb begin
        w_kq_g   = w_kq_side;
        w_kq_g.k = w_kq_prod[103 +: KB];
    end

    // k * ln2 for the remainder
    logic            w_kl_valid;
    logic [127:0]    w_kl_prod;
    ncdf_pkg::t_side w_kl_side;

    ncdf_mul u_kl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_kq_valid),
        .i_a(64'(w_kq_g.k)), .i_b(ncdf_pkg::LN2_C), .i_side(w_kq_g),
        .o_valid(w_kl_valid), .o_prod(w_kl_prod), .o_side(w_kl_side)
    );

    // one correction step settles k; r goes to w0
    logic            r_kc_valid;
    ncdf_pkg::t_side r_kc_side, n_kc_side;

    always_comb begin
        logic [63:0] v_r;
        v_r       = w_kl_side.w0 - w_kl_prod[63:0];
        n_kc_side = w_kl_side;
        if (v_r >= ncdf_pkg::LN2_C) begin
            n_kc_side.k  = w_kl_side.k + KB'(1);
            n_kc_side.w0 = v_r - ncdf_pkg::LN2_C;
        end else begin
            n_kc_side.w0 = v_r;
        end
    end

    // ---- exp(-r) by sixteen Taylor terms ----
    logic            w_ts_valid [NT+1];
    ncdf_pkg::t_side w_ts_side  [NT+1];

    assign w_ts_valid[0] = r_kc_valid;
    always_comb begin
        w_ts_side[0]    = r_kc_side;
        w_ts_side[0].w1 = ncdf_pkg::ONE_WF;
        w_ts_side[0].m  = ncdf_pkg::ONE_WF;
    end

    for (genvar i = 0; i < NT; i++) begin : g_taylor
        ncdf_tstep u_tstep (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_ts_valid[i]),
            .i_n(5'(i + 1)), .i_recip(ncdf_pkg::RECIP_C[i]), .i_side(w_ts_side[i]),
            .o_valid(w_ts_valid[i+1]), .o_side(w_ts_side[i+1])
        );
    end

    // ---- Horner: numerator P(a) in w0 ----
    logic            w_hn_valid [NN+1];
    ncdf_pkg::t_side w_hn_side  [NN+1];
    logic            w_hn_ovalid [NN];
    logic [127:0]    w_hn_prod   [NN];
    ncdf_pkg::t_side w_hn_oside  [NN];

    assign w_hn_valid[0] = w_ts_valid[NT];
    always_comb begin
        w_hn_side[0]    = w_ts_side[NT];
        w_hn_side[0].w0 = ncdf_pkg::NUM_C[0];
    end

    for (genvar j = 0; j < NN; j++) begin : g_hnum
        ncdf_mul u_mul (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_hn_valid[j]),
            .i_a(w_hn_side[j].w0), .i_b(w_hn_side[j].a), .i_side(w_hn_side[j]),
            .o_valid(w_hn_ovalid[j]), .o_prod(w_hn_prod[j]), .o_side(w_hn_oside[j])
        );
        assign w_hn_valid[j+1] = w_hn_ovalid[j];
        always_comb begin
            w_hn_side[j+1]    = w_hn_oside[j];
            w_hn_side[j+1].w0 = w_hn_prod[j][103:40] + ncdf_pkg::NUM_C[j+1];
        end
    end

    // ---- Horner: denominator Q(a) in w1 ----
    logic            w_hd_valid [ND+1];
    ncdf_pkg::t_side w_hd_side  [ND+1];
    logic            w_hd_ovalid [ND];
    logic [127:0]    w_hd_prod   [ND];
    ncdf_pkg::t_side w_hd_oside  [ND];

    assign w_hd_valid[0] = w_hn_valid[NN];
    always_comb begin
        w_hd_side[0]    = w_hn_side[NN];
        w_hd_side[0].w1 = ncdf_pkg::DEN_C[0];
    end

    for (genvar j = 0; j < ND; j++) begin : g_hden
        ncdf_mul u_mul (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_hd_valid[j]),
            .i_a(w_hd_side[j].w1), .i_b(w_hd_side[j].a), .i_side(w_hd_side[j]),
            .o_valid(w_hd_ovalid[j]), .o_prod(w_hd_prod[j]), .o_side(w_hd_oside[j])
        );
        assign w_hd_valid[j+1] = w_hd_ovalid[j];
        always_comb begin
            w_hd_side[j+1]    = w_hd_oside[j];
            w_hd_side[j+1].w1 = w_hd_prod[j][103:40] + ncdf_pkg::DEN_C[j+1];
        end
    end

    // ---- ratio P/Q, then t1 = m * ratio ----
    logic            w_rt_valid;
    logic [QB-1:0]   w_rt_quo;
    logic [63:0]     w_rt_rem;
    ncdf_pkg::t_side w_rt_side, w_rt_g;

    ncdf_div u_ratio (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_hd_valid[ND]),
        .i_num({24'b0, w_hd_side[ND].w0, 40'b0}), .i_den(w_hd_side[ND].w1),
        .i_side(w_hd_side[ND]),
        .o_valid(w_rt_valid), .o_quo(w_rt_quo), .o_rem(w_rt_rem), .o_side(w_rt_side)
    );

    always_comb begin
        w_rt_g    = w_rt_side;
        w_rt_g.w0 = 64'(w_rt_quo);
    end

    logic            w_t1_valid;
    logic [127:0]    w_t1_prod;
    ncdf_pkg::t_side w_t1_side;

    ncdf_mul u_t1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rt_valid),
        .i_a(w_rt_g.m), .i_b(w_rt_g.w0), .i_side(w_rt_g),
        .o_valid(w_t1_valid), .o_prod(w_t1_prod), .o_side(w_t1_side)
    );

    // ---- continued fraction b, innermost term first, in w1 ----
    logic            w_cf_valid [NC+1];
    ncdf_pkg::t_side w_cf_side  [NC+1];
    logic            w_cf_ovalid [NC];
    logic [QB-1:0]   w_cf_quo    [NC];
    logic [63:0]     w_cf_rem    [NC];
    ncdf_pkg::t_side w_cf_oside  [NC];

    assign w_cf_valid[0] = w_t1_valid;
    always_comb begin
        w_cf_side[0]    = w_t1_side;
        w_cf_side[0].t1 = w_t1_prod[103:40];
        w_cf_side[0].w1 = w_t1_side.a + ncdf_pkg::C065_C;
    end

    for (genvar d = 0; d < NC; d++) begin : g_cfrac
        ncdf_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_cf_valid[d]),
            .i_num(128'(NC - d) << (2 * ncdf_pkg::WF)), .i_den(w_cf_side[d].w1),
            .i_side(w_cf_side[d]),
            .o_valid(w_cf_ovalid[d]), .o_quo(w_cf_quo[d]), .o_rem(w_cf_rem[d]),
            .o_side(w_cf_oside[d])
        );
        assign w_cf_valid[d+1] = w_cf_ovalid[d];
        always_comb begin
            w_cf_side[d+1]    = w_cf_oside[d];
            w_cf_side[d+1].w1 = w_cf_oside[d].a + 64'(w_cf_quo[d]);
        end
    end

    // ---- m / b, then / sqrt(2*pi) ----
    logic            w_mb_valid;
    logic [QB-1:0]   w_mb_quo;
    logic [63:0]     w_mb_rem;
    ncdf_pkg::t_side w_mb_side, w_mb_g;

    ncdf_div u_mdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_cf_valid[NC]),
        .i_num(128'(w_cf_side[NC].m) << ncdf_pkg::WF), .i_den(w_cf_side[NC].w1),
        .i_side(w_cf_side[NC]),
        .o_valid(w_mb_valid), .o_quo(w_mb_quo), .o_rem(w_mb_rem), .o_side(w_mb_side)
    );

    always_comb begin
        w_mb_g    = w_mb_side;
        w_mb_g.w1 = 64'(w_mb_quo);
    end

    // quotient estimate by reciprocal, low by at most one, into w0
    logic            w_sr_valid;
    logic [127:0]    w_sr_prod;
    ncdf_pkg::t_side w_sr_side, w_sr_g;

    ncdf_mul u_srecip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_mb_valid),
        .i_a(w_mb_g.w1), .i_b(ncdf_pkg::RSQRT2PI_C), .i_side(w_mb_g),
        .o_valid(w_sr_valid), .o_prod(w_sr_prod), .o_side(w_sr_side)
    );

    always_comb begin
        w_sr_g    = w_sr_side;
        w_sr_g.w0 = w_sr_prod[127:64];
    end

    logic            w_sb_valid;
    logic [127:0]    w_sb_prod;
    ncdf_pkg::t_side w_sb_side;

    ncdf_mul u_sback (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_sr_valid),
        .i_a(w_sr_g.w0), .i_b(ncdf_pkg::SQRT2PI_C), .i_side(w_sr_g),
        .o_valid(w_sb_valid), .o_prod(w_sb_prod), .o_side(w_sb_side)
    );

    // remainder fits in 64 bits, so the low halves are enough
    logic            r_sc_valid;
    logic [63:0]     r_sc_q, n_sc_q;
    ncdf_pkg::t_side r_sc_side;

    always_comb begin
        logic [63:0] v_rem;
        v_rem = (w_sb_side.w1 << ncdf_pkg::WF) - w_sb_prod[63:0];
        if (v_rem >= ncdf_pkg::SQRT2PI_C) begin
            n_sc_q = w_sb_side.w0 + 64'd1;
        end else begin
            n_sc_q = w_sb_side.w0;
        end
    end

    // ---- branch select and scaling by 2^-k ----
    logic        r_fin_valid, r_fin_pos;
    logic [63:0] r_fin_tail, n_fin_tail;

    always_comb begin
        logic [63:0] v_t;
        logic [11:0] v_s;
        logic [11:0] v_ns;
        if (r_sc_side.big) begin
            v_t = 64'd0;                               // far tail is zero
        end else if (r_sc_side.a < ncdf_pkg::SPLIT_C) begin
            v_t = r_sc_side.t1;
        end else begin
            v_t = r_sc_q;
        end
        v_s  = 12'(r_sc_side.k) + 12'(ncdf_pkg::SHIFT_BIAS);
        v_ns = 12'(-v_s);
        if (v_s[11]) begin
            n_fin_tail = v_t << v_ns[5:0];
        end else if (v_s >= 12'd64) begin
            n_fin_tail = 64'd0;
        end else begin
            n_fin_tail = v_t >> v_s[5:0];
        end
    end

    // ---- 1 - tail for positive x, saturate to 32 bits ----
    logic        r_out_valid;
    logic [31:0] r_out_prob, n_out_prob;

    always_comb begin
        logic [63:0] v_one;
        logic [63:0] v_p;
        v_one = 64'd1 << ncdf_pkg::OUT_FRAC_BITS;
        if (r_fin_pos) begin
            v_p = (r_fin_tail >= v_one) ? 64'd0 : (v_one - r_fin_tail);
        end else begin
            v_p = r_fin_tail;
        end
        n_out_prob = (v_p > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v_p[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kc_valid  <= 1'b0;
            r_sc_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_kc_valid  <= w_kl_valid;
            r_sc_valid  <= w_sb_valid;
            r_fin_valid <= r_sc_valid;
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kc_side  <= n_kc_side;
            r_sc_q     <= n_sc_q;
            r_sc_side  <= w_sb_side;
            r_fin_tail <= n_fin_tail;
            r_fin_pos  <= r_sc_side.pos;
            r_out_prob <= n_out_prob;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_probability = r_out_prob;

endmodule

// ===== sv/ncdf_mul.sv =====
// Two-stage 64x64 multiplier built from four 32x32 partial products, sideband delayed alongside.
module ncdf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    input  ncdf_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [127:0]        o_prod,
    output ncdf_pkg::t_side     o_side
);

    logic [1:0]      r_valid;
    logic [63:0]     r_ll, r_lh, r_hl, r_hh;
    ncdf_pkg::t_side r_side1, r_side2;
    logic [127:0]    r_prod;
    logic [127:0]    n_prod;

    always_comb begin
        n_prod = {64'b0, r_ll} + ({64'b0, r_lh} << 32) + ({64'b0, r_hl} << 32)
               + ({64'b0, r_hh} << 64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_lh    <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_hl    <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_hh    <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            r_side1 <= i_side;
            r_prod  <= n_prod;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_valid[1];
    assign o_prod  = r_prod;
    assign o_side  = r_side2;

endmodule

// ===== sv/ncdf_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, remainder out at the end.
module ncdf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [127:0]                      i_num,
    input  logic [63:0]                       i_den,
    input  ncdf_pkg::t_side                   i_side,
    output logic                              o_valid,
    output logic [ncdf_pkg::DIV_QBITS-1:0]    o_quo,
    output logic [63:0]                       o_rem,
    output ncdf_pkg::t_side                   o_side
);

    localparam int QB = ncdf_pkg::DIV_QBITS;

    logic [QB-1:0]   r_valid;
    logic [63:0]     r_rem  [QB];
    logic [63:0]     r_den  [QB];
    logic [QB-1:0]   r_low  [QB];
    logic [QB-1:0]   r_quo  [QB];
    ncdf_pkg::t_side r_side [QB];
    logic [63:0]     n_rem  [QB];
    logic [QB-1:0]   n_low  [QB];
    logic [QB-1:0]   n_quo  [QB];

    // each stage reads only the register before it
    always_comb begin
        logic [63:0]   v_rem;
        logic [63:0]   v_den;
        logic [QB-1:0] v_low;
        logic [QB-1:0] v_quo;
        logic [64:0]   v_trial;
        logic          v_ge;
        for (int j = 0; j < QB; j++) begin
            if (j == 0) begin
                v_rem = i_num[QB+63:QB];
                v_low = i_num[QB-1:0];
                v_quo = '0;
                v_den = i_den;
            end else begin
                v_rem = r_rem[j-1];
                v_low = r_low[j-1];
                v_quo = r_quo[j-1];
                v_den = r_den[j-1];
            end
            v_trial = {v_rem, v_low[QB-1]};
            v_ge    = (v_trial >= {1'b0, v_den});
            if (v_ge) begin
                n_rem[j] = 64'(v_trial - {1'b0, v_den});
            end else begin
                n_rem[j] = v_trial[63:0];
            end
            n_quo[j] = {v_quo[QB-2:0], v_ge};
            n_low[j] = {v_low[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QB-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QB; j++) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_quo[j] <= n_quo[j];
                if (j == 0) begin
                    r_den[j]  <= i_den;
                    r_side[j] <= i_side;
                end else begin
                    r_den[j]  <= r_den[j-1];
                    r_side[j] <= r_side[j-1];
                end
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_rem   = r_rem[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ===== sv/ncdf_tstep.sv =====
// One Taylor term of exp(-r): term = (term*r)/n, then m -/+ term; six stages.
module ncdf_tstep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [4:0]      i_n,
    input  logic [63:0]     i_recip,
    input  ncdf_pkg::t_side i_side,
    output logic            o_valid,
    output ncdf_pkg::t_side o_side
);

    // side.w0 = r, side.w1 = term, side.m = running sum
    logic            w_v1, w_v2;
    logic [127:0]    w_p1, w_p2;
    ncdf_pkg::t_side w_s1, w_s1g, w_s2;

    logic            r_c1_valid, r_c2_valid;
    logic [63:0]     r_c1_q;
    ncdf_pkg::t_side r_c1_side, r_c2_side;
    logic [63:0]     n_c1_q;
    ncdf_pkg::t_side n_c2_side;

    ncdf_mul u_mul_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_valid(i_valid),
        .i_a(i_side.w1), .i_b(i_side.w0), .i_side(i_side),
        .o_valid(w_v1), .o_prod(w_p1), .o_side(w_s1)
    );

    always_comb begin
        w_s1g    = w_s1;
        w_s1g.w1 = w_p1[103:40];
    end

    ncdf_mul u_mul_n (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_valid(w_v1),
        .i_a(w_p1[103:40]), .i_b(i_recip), .i_side(w_s1g),
        .o_valid(w_v2), .o_prod(w_p2), .o_side(w_s2)
    );

    // reciprocal estimate is low by at most one
    always_comb begin
        logic [63:0] v_q0;
        logic [63:0] v_rem;
        v_q0  = w_p2[127:64];
        v_rem = w_s2.w1 - (v_q0 * {59'b0, i_n});
        if (v_rem >= {59'b0, i_n}) begin
            n_c1_q = v_q0 + 64'd1;
        end else begin
            n_c1_q = v_q0;
        end
    end

    always_comb begin
        n_c2_side    = r_c1_side;
        n_c2_side.w1 = r_c1_q;
        if (i_n[0]) begin
            n_c2_side.m = r_c1_side.m - r_c1_q;
        end else begin
            n_c2_side.m = r_c1_side.m + r_c1_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid <= 1'b0;
            r_c2_valid <= 1'b0;
        end else if (i_en) begin
            r_c1_valid <= w_v2;
            r_c2_valid <= r_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1_q    <= n_c1_q;
            r_c1_side <= w_s2;
            r_c2_side <= n_c2_side;
        end
    end

    assign o_valid = r_c2_valid;
    assign o_side  = r_c2_side;

endmodule

// ===== sv/ncdf_chk.sv =====
// Port-level checker for the normal CDF pipeline, bound to the top level.
module ncdf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_x_value,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_probability
);

    // a held result word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_probability))
        else $error("result word changed while stalled");

    // input stalls only behind a stalled result
    a_stall_src: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word shown straight after reset");

endmodule

bind normal_cdf_rational ncdf_chk u_ncdf_chk (.*);

// ===== tb/normal_cdf_rational_test.sv =====
// Self-checking testbench for the normal CDF pipeline: table-driven directed words, then random.
`timescale 1ns / 100ps

module normal_cdf_rational_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_x_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_probability;

    normal_cdf_rational dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x_value(i_x_value), .o_valid(o_valid), .i_stall(i_stall),
        .o_probability(o_probability)
    );

    always #5 i_clk = ~i_clk;

    // Idle phases: none, sender only, receiver only, both sparse.
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    localparam int  LATENCY   = 386;
    localparam int  N_RANDOM  = 1030;

    logic [31:0] prob_queue [$];
    int          n_fail = 0;
    int          phase = PH_NONE;
    bit          hold_rx = 1'b0;

    // Directed table: argument and, where obvious, the typed-in result.
    typedef struct {
        logic [31:0] x;
        bit          known;
        logic [31:0] p;
    } t_row;

    localparam int N_DIR = 20;
    t_row dir_tab [N_DIR] = '{
        '{32'h0000_0000, 1'b0, 32'h0},                // zero: tail branch
        '{32'h8000_0000, 1'b1, 32'h0000_0000},        // most negative: large argument
        '{32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF},        // most positive: saturates
        '{32'h0025_0001, 1'b1, 32'hFFFF_FFFF},        // just above 37
        '{32'hFFDA_FFFF, 1'b1, 32'h0000_0000},        // just below -37
        '{32'h0025_0000, 1'b0, 32'h0},                // exactly 37
        '{32'hFFDB_0000, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0001_0000, 1'b0, 32'h0},
        '{32'hFFFF_0000, 1'b0, 32'h0},
        '{32'h0007_1211, 1'b0, 32'h0},                // around the 7.07 split
        '{32'h0007_1212, 1'b0, 32'h0},
        '{32'hFFF8_EDEE, 1'b0, 32'h0},
        '{32'hFFF8_EDEF, 1'b0, 32'h0},
        '{32'hFFF9_0000, 1'b0, 32'h0},                // tiny tail, rational branch
        '{32'hFFF7_0000, 1'b0, 32'h0},                // tail below one unit
        '{32'h0003_8000, 1'b0, 32'h0},
        '{32'hFFFD_8000, 1'b0, 32'h0},
        '{32'h0020_0000, 1'b0, 32'h0}
    };

    // floor(a*b / 2^WF)
    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod >> ncdf_pkg::WF);
    endfunction

    // floor(n * 2^WF / d)
    function automatic logic [63:0] fx_div(logic [63:0] n, logic [63:0] d);
        logic [127:0] num;
        if (d == 0) return '1;
        num = {64'd0, n} << ncdf_pkg::WF;
        return 64'(num / {64'd0, d});
    endfunction

    function automatic logic [63:0] dec_fix(logic [127:0] mant, logic [127:0] pw10);
        return 64'((mant << ncdf_pkg::WF) / pw10);
    endfunction

    // Predicted Phi(x) in unsigned Q0.32
    function automatic logic [31:0] predict_phi(logic [31:0] x);
        logic [63:0] mag, a, y, ln2, k, r, m, term, t, b, pn, qd, tail, p, one;
        logic [63:0] num_c [7];
        logic [63:0] den_c [8];
        bit          neg, pos;
        int          s;
        neg  = x[31];
        pos  = !neg && (x != 0);
        mag  = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
        tail = 0;
        one  = 64'd1 << ncdf_pkg::OUT_FRAC_BITS;
        num_c = '{dec_fix(128'd352624965998911, ncdf_pkg::E16),
                  dec_fix(128'd700383064443688, ncdf_pkg::E15),
                  dec_fix(128'd637396220353165, ncdf_pkg::E14),
                  dec_fix(128'd33912866078383, ncdf_pkg::E12),
                  dec_fix(128'd112079291497871, ncdf_pkg::E12),
                  dec_fix(128'd221213596169931, ncdf_pkg::E12),
                  dec_fix(128'd220206867912376, ncdf_pkg::E12)};
        den_c = '{dec_fix(128'd883883476483184, ncdf_pkg::E16),
                  dec_fix(128'd175566716318264, ncdf_pkg::E14),
                  dec_fix(128'd16064177579207, ncdf_pkg::E12),
                  dec_fix(128'd867807322029461, ncdf_pkg::E13),
                  dec_fix(128'd296564248779674, ncdf_pkg::E12),
                  dec_fix(128'd637333633378831, ncdf_pkg::E12),
                  dec_fix(128'd793826512519948, ncdf_pkg::E12),
                  dec_fix(128'd440413735824752, ncdf_pkg::E12)};
        if (mag <= (64'd37 << ncdf_pkg::IN_FRAC_BITS)) begin
            a    = mag << (ncdf_pkg::WF - ncdf_pkg::IN_FRAC_BITS);
            y    = fx_mul(a, a) >> 1;
            ln2  = dec_fix(128'd693147180559945309, ncdf_pkg::E18);
            k    = y / ln2;
            r    = y - k * ln2;
            m    = 64'd1 << ncdf_pkg::WF;
            term = m;
            for (int n = 1; n <= 16; n++) begin
                term = fx_mul(term, r) / n;
                if (n % 2) m = m - term;
                else m = m + term;
            end
            if (a < dec_fix(128'd707106781186547, ncdf_pkg::E14)) begin
                pn = num_c[0];
                qd = den_c[0];
                for (int n = 1; n < 7; n++) pn = fx_mul(pn, a) + num_c[n];
                for (int n = 1; n < 8; n++) qd = fx_mul(qd, a) + den_c[n];
                t = fx_mul(m, fx_div(pn, qd));
            end else begin
                b = a + dec_fix(128'd65, ncdf_pkg::E2);
                for (int n = 4; n >= 1; n--) b = a + fx_div(64'(n) << ncdf_pkg::WF, b);
                t = fx_div(fx_div(m, b), dec_fix(128'd2506628274631, ncdf_pkg::E12));
            end
            s = int'(k) + ncdf_pkg::SHIFT_BIAS;
            if (s >= 64) tail = 0;
            else if (s >= 0) tail = t >> s;
            else tail = t << (-s);
        end
        p = pos ? ((tail >= one) ? 64'd0 : one - tail) : tail;
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        return p[31:0];
    endfunction

    // Offer one word, holding it until taken; idle cycles drawn one at a time.
    task automatic send_word(logic [31:0] x, bit known, logic [31:0] p);
        int gap;
        gap = 0;
        if (phase == PH_SEND)
            while ($urandom_range(99) < 63) gap++;
        if (phase == PH_BOTH)
            while ($urandom_range(99) < 8) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        prob_queue.push_back(known ? p : predict_phi(x));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_x();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) *
                           ($urandom_range(1) ? 1 : -1));
            2: return 32'($signed($urandom_range(0, 32'h0026_0000)) *
                           ($urandom_range(1) ? 1 : -1));
            default: return 32'($signed($urandom_range(32'h0006_8000, 32'h0007_8000)) *
                           ($urandom_range(1) ? 1 : -1));
        endcase
    endfunction

    // Receiver stall pattern per phase; a long hold-off overrides it.
    always @(posedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else if (phase == PH_RECV) i_stall <= ($urandom_range(99) < 63);
        else if (phase == PH_BOTH) i_stall <= ($urandom_range(99) < 8);
        else i_stall <= 1'b0;
    end

    // Output checker: each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (prob_queue.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_probability);
                n_fail++;
            end else begin
                if (o_probability !== prob_queue[0]) begin
                    $display("%0t: probability expected %h actual %h",
                             $time, prob_queue[0], o_probability);
                    n_fail++;
                end
                void'(prob_queue.pop_front());
            end
        end
    end

    // Long receiver hold-off, counted in cycles here, while words keep coming.
    task automatic hold_off_rx(int cycles);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_word(dir_tab[i].x, dir_tab[i].known, dir_tab[i].p);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 250 == 0) phase = (i / 250) % 4;
            if (i == 100) fork hold_off_rx(900); join_none
            if (i == 600) begin
                // sender pause until the pipeline has drained
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (prob_queue.size() != 0) @(posedge i_clk);
            end
            send_word(rand_x(), 1'b0, 32'h0);
        end
        i_valid <= 1'b0;
        phase = PH_NONE;

        while (prob_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        if (n_fail == 0 && prob_queue.size() == 0)
            $display("normal_cdf_rational: match");
        else
            $display("normal_cdf_rational: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("normal_cdf_rational: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ncdf_pkg.sv
sv/ncdf_mul.sv
sv/ncdf_div.sv
sv/ncdf_tstep.sv
sv/normal_cdf_rational.sv
sv/ncdf_chk.sv
tb/normal_cdf_rational_test.sv
